@@ rtl/pprx_pkg.sv @@
// Shared constants, codes and types for the ping-pong receive framer.
`timescale 1ns / 1ps

package pprx_pkg;

    localparam int BANK_BYTES = 2048;
    localparam int IDX_W      = $clog2(BANK_BYTES);
    localparam int LEN_W      = IDX_W + 1;
    localparam int MEM_AW     = IDX_W + 1;
    localparam int MEM_DEPTH  = 2 * BANK_BYTES;
    localparam int ACTION_W   = 3;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_BYTE     = 3'd0,
        ACT_TIMEOUT  = 3'd1,
        ACT_LINE_ERR = 3'd2,
        ACT_POLL     = 3'd3,
        ACT_RELEASE  = 3'd4,
        ACT_READ     = 3'd5
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_NOTHING  = 3'd0,
        ST_HANDOFF  = 3'd1,
        ST_BUSY     = 3'd2,
        ST_ERROR    = 3'd3,
        ST_READ     = 3'd4,
        ST_STORED   = 3'd5,
        ST_OVERFLOW = 3'd6
    } t_status;

    typedef struct packed {
        logic              we;
        logic              re;
        logic [MEM_AW-1:0] addr;
        logic [BYTE_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        t_status          status;
        logic [LEN_W-1:0] len;
        logic             bank;
        logic             held;
        logic             rd_hit;
    } t_meta;

    typedef struct packed {
        t_status           status;
        logic [LEN_W-1:0]  len;
        logic              bank;
        logic              held;
        logic [BYTE_W-1:0] read_data;
    } t_result;

endpackage

@@ rtl/pprx_if.sv @@
// Valid/ready channel interfaces for framer input items and result items.
`timescale 1ns / 1ps

interface pprx_in_if;
    logic                          valid;
    logic                          ready;
    logic [pprx_pkg::ACTION_W-1:0] action;
    logic [pprx_pkg::BYTE_W-1:0]   rx_byte;
    logic [pprx_pkg::IDX_W-1:0]    read_index;

    modport source (output valid, output action, output rx_byte, output read_index,
                    input ready);
    modport sink   (input valid, input action, input rx_byte, input read_index,
                    output ready);
endinterface

interface pprx_out_if;
    logic                          valid;
    logic                          ready;
    logic [pprx_pkg::STATUS_W-1:0] status;
    logic [pprx_pkg::LEN_W-1:0]    packet_len;
    logic                          packet_bank;
    logic                          packet_held;
    logic [pprx_pkg::BYTE_W-1:0]   read_data;

    modport source (output valid, output status, output packet_len, output packet_bank,
                    output packet_held, output read_data, input ready);
    modport sink   (input valid, input status, input packet_len, input packet_bank,
                    input packet_held, input read_data, output ready);
endinterface

@@ rtl/pprx_bank_ram.sv @@
// Two-bank byte store: one access per cycle, registered read data.
`timescale 1ns / 1ps

module pprx_bank_ram (
    input  logic                        i_clk,
    input  pprx_pkg::t_mem_req          i_req,
    output logic [pprx_pkg::BYTE_W-1:0] o_rdata
);

    logic [pprx_pkg::BYTE_W-1:0] mem [pprx_pkg::MEM_DEPTH];
    logic [pprx_pkg::BYTE_W-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
    end

    // hold read data until the next read so a stalled result keeps its byte
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_q <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_q;

endmodule

@@ rtl/pprx_ctrl.sv @@
// Framer control: fill and hold state, memory request issue, result stage.
`timescale 1ns / 1ps

module pprx_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pprx_in_if.sink            i_item,
    input  logic               i_a_ready,
    output logic               o_a_valid,
    output pprx_pkg::t_meta    o_a_meta,
    output pprx_pkg::t_mem_req o_mem_req
);

    localparam logic [pprx_pkg::LEN_W-1:0] FULL = pprx_pkg::LEN_W'(pprx_pkg::BANK_BYTES);

    logic [pprx_pkg::LEN_W-1:0] r_fill, n_fill;
    logic [pprx_pkg::LEN_W-1:0] r_last, n_last;
    logic                       r_active, n_active;
    logic                       r_held, n_held;
    logic [pprx_pkg::LEN_W-1:0] r_held_len, n_held_len;
    logic                       r_held_bank, n_held_bank;
    logic                       r_a_valid;
    pprx_pkg::t_meta            r_a_meta, n_meta;
    pprx_pkg::t_mem_req         req;
    logic                       accept;

    assign i_item.ready = i_rst_n && (!r_a_valid || i_a_ready);
    assign accept       = i_item.valid && i_item.ready;

    always_comb begin
        n_fill        = r_fill;
        n_last        = r_last;
        n_active      = r_active;
        n_held        = r_held;
        n_held_len    = r_held_len;
        n_held_bank   = r_held_bank;
        n_meta        = '0;
        n_meta.status = pprx_pkg::ST_NOTHING;
        req           = '0;
        req.wdata     = i_item.rx_byte;
        case (i_item.action)
            pprx_pkg::ACT_BYTE: begin
                if (r_fill < FULL) begin
                    req.we        = accept;
                    req.addr      = {r_active, r_fill[pprx_pkg::IDX_W-1:0]};
                    n_fill        = r_fill + 1'b1;
                    n_meta.status = pprx_pkg::ST_STORED;
                end else begin
                    n_meta.status = pprx_pkg::ST_OVERFLOW;
                end
            end
            pprx_pkg::ACT_TIMEOUT: begin
                if (r_held) begin
                    n_fill        = '0;
                    n_meta.status = pprx_pkg::ST_BUSY;
                end else if (r_fill != '0) begin
                    n_held_len    = r_fill;
                    n_held_bank   = r_active;
                    n_held        = 1'b1;
                    n_active      = ~r_active;
                    n_fill        = '0;
                    n_meta.status = pprx_pkg::ST_HANDOFF;
                end
            end
            pprx_pkg::ACT_LINE_ERR: begin
                n_fill        = '0;
                n_meta.status = pprx_pkg::ST_ERROR;
            end
            pprx_pkg::ACT_POLL: begin
                // close on a quiet line: count unchanged since the last tick
                if (r_fill != '0 && r_fill == r_last) begin
                    if (r_held) begin
                        n_meta.status = pprx_pkg::ST_BUSY;
                    end else begin
                        n_held_len    = r_fill;
                        n_held_bank   = r_active;
                        n_held        = 1'b1;
                        n_active      = ~r_active;
                        n_meta.status = pprx_pkg::ST_HANDOFF;
                    end
                    n_fill = '0;
                    n_last = '0;
                end else begin
                    n_last = r_fill;
                end
            end
            pprx_pkg::ACT_RELEASE: begin
                n_held = 1'b0;
            end
            pprx_pkg::ACT_READ: begin
                n_meta.status = pprx_pkg::ST_READ;
                n_meta.rd_hit = r_held && ({1'b0, i_item.read_index} < r_held_len);
                req.re        = accept && n_meta.rd_hit;
                req.addr      = {r_held_bank, i_item.read_index};
            end
            default: begin
            end
        endcase
        n_meta.held = n_held;
        n_meta.len  = n_held ? n_held_len : '0;
        n_meta.bank = n_held ? n_held_bank : 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_last      <= '0;
            r_active    <= 1'b0;
            r_held      <= 1'b0;
            r_held_len  <= '0;
            r_held_bank <= 1'b0;
            r_a_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_fill      <= n_fill;
                r_last      <= n_last;
                r_active    <= n_active;
                r_held      <= n_held;
                r_held_len  <= n_held_len;
                r_held_bank <= n_held_bank;
                r_a_valid   <= 1'b1;
            end else if (i_a_ready) begin
                r_a_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_meta <= n_meta;
        end
    end

    assign o_a_valid = r_a_valid;
    assign o_a_meta  = r_a_meta;
    assign o_mem_req = req;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FULL)
        else $error("fill count beyond bank capacity");

    a_banks_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_held_bank != r_active))
        else $error("held bank is also the active fill bank");

    a_held_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held |-> (r_held_len != '0 && r_held_len <= FULL))
        else $error("held packet length out of range");

    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !i_a_ready) |=> (r_a_valid && $stable(r_a_meta)))
        else $error("stalled result stage changed");

endmodule

@@ rtl/pprx_skid.sv @@
// Two-entry output skid buffer with registered ready toward the result stage.
`timescale 1ns / 1ps

module pprx_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  pprx_pkg::t_result i_data,
    output logic              o_ready,
    pprx_out_if.source        o_result
);

    logic              r_main_v;
    logic              r_spare_v;
    pprx_pkg::t_result r_main;
    pprx_pkg::t_result r_spare;
    logic              push;
    logic              pop;

    assign o_ready = !r_spare_v;
    assign push    = i_valid && o_ready;
    assign pop     = r_main_v && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v  <= 1'b0;
            r_spare_v <= 1'b0;
        end else if (!r_main_v || pop) begin
            if (r_spare_v) begin
                r_main_v  <= 1'b1;
                r_spare_v <= 1'b0;
            end else begin
                r_main_v  <= push;
            end
        end else if (push) begin
            r_spare_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_v || pop) begin
            r_main <= r_spare_v ? r_spare : i_data;
        end else if (push) begin
            r_spare <= i_data;
        end
    end

    assign o_result.valid       = r_main_v;
    assign o_result.status      = r_main.status;
    assign o_result.packet_len  = r_main.len;
    assign o_result.packet_bank = r_main.bank;
    assign o_result.packet_held = r_main.held;
    assign o_result.read_data   = r_main.read_data;

    a_spare_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare_v |-> r_main_v)
        else $error("spare entry filled while main entry empty");

endmodule

@@ rtl/pingpong_rx_idle_framer.sv @@
// Top level of the ping-pong receive framer with idle-timeout packet close.
`timescale 1ns / 1ps

// Each result is registered in the control and byte-store stage, then in the output skid
//   register. The single store port serves at most one write or read per item.
// Throughput: one item per cycle while the result path is not stalled.
// Reset: synchronous, active low; clears fill, hold and pipeline state.
// The byte store is not cleared; only bytes of a held packet are ever read back.
module pingpong_rx_idle_framer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pprx_in_if.sink     i_item,
    pprx_out_if.source  o_result
);

    logic                        a_valid;
    logic                        a_ready;
    pprx_pkg::t_meta             a_meta;
    pprx_pkg::t_mem_req          mem_req;
    logic [pprx_pkg::BYTE_W-1:0] ram_q;
    pprx_pkg::t_result           a_result;

    // Decode the transaction, update fill/hold state, issue the store access.
    pprx_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (i_item),
        .i_a_ready (a_ready),
        .o_a_valid (a_valid),
        .o_a_meta  (a_meta),
        .o_mem_req (mem_req)
    );

    // Both banks live in one array; the bank bit is the address MSB.
    pprx_bank_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (ram_q)
    );

    // Merge read data: zero unless the read hit inside the held packet.
    always_comb begin
        a_result.status    = a_meta.status;
        a_result.len       = a_meta.len;
        a_result.bank      = a_meta.bank;
        a_result.held      = a_meta.held;
        a_result.read_data = a_meta.rd_hit ? ram_q : '0;
    end

    // Decouple the result consumer from the input side.
    pprx_skid u_skid (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (a_valid),
        .i_data   (a_result),
        .o_ready  (a_ready),
        .o_result (o_result)
    );

endmodule
